@@ rtl/assert_macros.svh @@
// assertion macros shared by the ray caster modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define GDDA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define GDDA_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/gdda_pkg.sv @@
// types and constants of the grid dda ray caster
package gdda_pkg;

   // item opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   // register indexes
   localparam logic CSR_MAP_COLS = 1'b0;
   localparam logic CSR_MAP_ROWS = 1'b1;

   // map geometry
   localparam logic [6:0]  MAP_DIM     = 7'd64;
   localparam logic [11:0] CLEAR_LAST  = 12'd4095;
   localparam logic [21:0] CELL_Q6     = 22'd4096;
   localparam logic [8:0]  STEP_GUARD  = 9'd272;

   // sine polynomial coefficients, q14
   localparam logic [14:0] SIN_A       = 15'd25736;
   localparam logic [14:0] SIN_B       = 15'd10512;
   localparam logic [23:0] SIN_C       = 24'd1160;
   localparam logic [14:0] SIN_ONE     = 15'd16384;
   localparam logic [15:0] QUARTER     = 16'h4000;

   // distance and span
   localparam logic [23:0] DIST_MAX    = 24'hFFFFFF;
   localparam logic [15:0] DEN_K       = 16'd10000;
   localparam logic [37:0] DEN_BIAS    = 38'd256;
   localparam logic [36:0] HN          = 37'd78643200000;
   localparam logic [8:0]  SCREEN_ROWS = 9'd480;
   localparam logic [7:0]  SHADE_V     = 8'd255;
   localparam logic [7:0]  SHADE_H     = 8'd200;

   typedef struct packed {
      logic        op;
      logic [5:0]  cell_col;
      logic [5:0]  cell_row;
      logic        cell_is_wall;
      logic [17:0] pos_x;
      logic [17:0] pos_y;
      logic [11:0] ray_angle;
      logic [9:0]  column;
   } req_type;

   typedef struct packed {
      logic [9:0]  out_column;
      logic        hit_side;
      logic        left_map;
      logic [23:0] wall_distance;
      logic [7:0]  span_start;
      logic [8:0]  span_end;
      logic [7:0]  wall_shade;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_SIN_LOAD, ST_SIN_M1, ST_SIN_M2, ST_SIN_M3, ST_SIN_M4,
      ST_INIT, ST_PROD_A, ST_PROD_B, ST_STEP, ST_TEST, ST_DIST, ST_DIV1,
      ST_DLOAD, ST_DEN, ST_SPAN, ST_DIV2, ST_OUT
   } state_type;

   typedef enum logic [4:0] {
      DP_IDLE, DP_CLEAR, DP_SIN_LOAD, DP_SIN_M1, DP_SIN_M2, DP_SIN_M3, DP_SIN_M4,
      DP_INIT, DP_PROD_A, DP_PROD_B, DP_STEP, DP_TEST, DP_DIST, DP_DIV,
      DP_DLOAD, DP_DEN, DP_SPAN
   } dp_op_type;

   typedef struct packed {
      dp_op_type   op;
      logic        axis_y;
      logic        force_left;
      logic        out_load;
      logic        capture;
      logic        cell_write;
      logic [11:0] clr_addr;
   } cmd_type;

   typedef struct packed {
      logic out_of_map;
      logic wall;
      logic dist_sat;
      logic span_clamp;
      logic out_free;
   } status_type;

endpackage

@@ rtl/gdda_ctrl.sv @@
// sequencer of the ray caster: map clearing, sine, stepping and division phases
`include "assert_macros.svh"

module gdda_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_op,
   output logic                  req_stall,
   input  gdda_pkg::status_type  status,
   output gdda_pkg::cmd_type     cmd
);

   gdda_pkg::state_type state_ff, state_in;
   logic        axis_ff, axis_in;
   logic [4:0]  iter_ff, iter_in;
   logic [8:0]  guard_ff, guard_in;
   logic [11:0] clr_ff, clr_in;
   logic        accept;
   logic        guard_done;

   assign accept     = req_valid && (state_ff == gdda_pkg::ST_IDLE);
   assign guard_done = guard_ff >= gdda_pkg::STEP_GUARD;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gdda_pkg::ST_CLEAR;
         axis_ff  <= 1'b0;
         iter_ff  <= '0;
         guard_ff <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         iter_ff  <= iter_in;
         guard_ff <= guard_in;
         clr_ff   <= clr_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      iter_in  = iter_ff;
      guard_in = guard_ff;
      clr_in   = clr_ff;
      case (state_ff)
         gdda_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 12'd1;
            if (clr_ff == gdda_pkg::CLEAR_LAST) state_in = gdda_pkg::ST_IDLE;
         end
         gdda_pkg::ST_IDLE: begin
            if (accept && (req_op == gdda_pkg::OP_CAST)) begin
               axis_in  = 1'b0;
               state_in = gdda_pkg::ST_SIN_LOAD;
            end
         end
         gdda_pkg::ST_SIN_LOAD: state_in = gdda_pkg::ST_SIN_M1;
         gdda_pkg::ST_SIN_M1:   state_in = gdda_pkg::ST_SIN_M2;
         gdda_pkg::ST_SIN_M2:   state_in = gdda_pkg::ST_SIN_M3;
         gdda_pkg::ST_SIN_M3:   state_in = gdda_pkg::ST_SIN_M4;
         gdda_pkg::ST_SIN_M4: begin
            if (!axis_ff) begin
               axis_in  = 1'b1;
               state_in = gdda_pkg::ST_SIN_LOAD;
            end else begin
               state_in = gdda_pkg::ST_INIT;
            end
         end
         gdda_pkg::ST_INIT:   state_in = gdda_pkg::ST_PROD_A;
         gdda_pkg::ST_PROD_A: state_in = gdda_pkg::ST_PROD_B;
         gdda_pkg::ST_PROD_B: begin
            guard_in = '0;
            state_in = gdda_pkg::ST_STEP;
         end
         gdda_pkg::ST_STEP: state_in = gdda_pkg::ST_TEST;
         gdda_pkg::ST_TEST: begin
            if (status.out_of_map || status.wall || guard_done) begin
               state_in = gdda_pkg::ST_DIST;
            end else begin
               guard_in = guard_ff + 9'd1;
               state_in = gdda_pkg::ST_STEP;
            end
         end
         gdda_pkg::ST_DIST: begin
            if (status.dist_sat) begin
               state_in = gdda_pkg::ST_DEN;
            end else begin
               iter_in  = 5'd23;
               state_in = gdda_pkg::ST_DIV1;
            end
         end
         gdda_pkg::ST_DIV1: begin
            if (iter_ff == 5'd0) state_in = gdda_pkg::ST_DLOAD;
            else iter_in = iter_ff - 5'd1;
         end
         gdda_pkg::ST_DLOAD: state_in = gdda_pkg::ST_DEN;
         gdda_pkg::ST_DEN:   state_in = gdda_pkg::ST_SPAN;
         gdda_pkg::ST_SPAN: begin
            if (status.span_clamp) begin
               state_in = gdda_pkg::ST_OUT;
            end else begin
               iter_in  = 5'd8;
               state_in = gdda_pkg::ST_DIV2;
            end
         end
         gdda_pkg::ST_DIV2: begin
            if (iter_ff == 5'd0) state_in = gdda_pkg::ST_OUT;
            else iter_in = iter_ff - 5'd1;
         end
         gdda_pkg::ST_OUT: begin
            if (status.out_free) state_in = gdda_pkg::ST_IDLE;
         end
         default: state_in = gdda_pkg::ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd            = '0;
      cmd.op         = gdda_pkg::DP_IDLE;
      cmd.axis_y     = axis_ff;
      cmd.clr_addr   = clr_ff;
      cmd.capture    = accept;
      cmd.cell_write = accept && (req_op == gdda_pkg::OP_WRITE);
      req_stall      = state_ff != gdda_pkg::ST_IDLE;
      case (state_ff)
         gdda_pkg::ST_CLEAR:    cmd.op = gdda_pkg::DP_CLEAR;
         gdda_pkg::ST_SIN_LOAD: cmd.op = gdda_pkg::DP_SIN_LOAD;
         gdda_pkg::ST_SIN_M1:   cmd.op = gdda_pkg::DP_SIN_M1;
         gdda_pkg::ST_SIN_M2:   cmd.op = gdda_pkg::DP_SIN_M2;
         gdda_pkg::ST_SIN_M3:   cmd.op = gdda_pkg::DP_SIN_M3;
         gdda_pkg::ST_SIN_M4:   cmd.op = gdda_pkg::DP_SIN_M4;
         gdda_pkg::ST_INIT:     cmd.op = gdda_pkg::DP_INIT;
         gdda_pkg::ST_PROD_A:   cmd.op = gdda_pkg::DP_PROD_A;
         gdda_pkg::ST_PROD_B:   cmd.op = gdda_pkg::DP_PROD_B;
         gdda_pkg::ST_STEP:     cmd.op = gdda_pkg::DP_STEP;
         gdda_pkg::ST_TEST: begin
            cmd.op         = gdda_pkg::DP_TEST;
            cmd.force_left = guard_done;
         end
         gdda_pkg::ST_DIST:     cmd.op = gdda_pkg::DP_DIST;
         gdda_pkg::ST_DIV1:     cmd.op = gdda_pkg::DP_DIV;
         gdda_pkg::ST_DLOAD:    cmd.op = gdda_pkg::DP_DLOAD;
         gdda_pkg::ST_DEN:      cmd.op = gdda_pkg::DP_DEN;
         gdda_pkg::ST_SPAN:     cmd.op = gdda_pkg::DP_SPAN;
         gdda_pkg::ST_DIV2:     cmd.op = gdda_pkg::DP_DIV;
         gdda_pkg::ST_OUT:      cmd.out_load = status.out_free;
         default:               cmd.op = gdda_pkg::DP_IDLE;
      endcase
   end

   // checks
   `GDDA_ASSERT(a_load_free, clock, reset, cmd.out_load |-> status.out_free, "result load while output full")
   `GDDA_ASSERT_NEXT(a_div_end, clock, reset, (state_ff == gdda_pkg::ST_DIV1) && (iter_ff == 5'd0), state_ff == gdda_pkg::ST_DLOAD, "distance divide did not finish")
   `GDDA_ASSERT_NEXT(a_out_hold, clock, reset, (state_ff == gdda_pkg::ST_OUT) && !status.out_free, state_ff == gdda_pkg::ST_OUT, "result dropped")

endmodule

@@ rtl/gdda_dp.sv @@
// datapath of the ray caster: wall map, sine unit, grid stepper, divider, result register
`include "assert_macros.svh"

module gdda_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  gdda_pkg::req_type     req_data,
   input  logic                  csr_valid,
   input  logic                  csr_index,
   input  logic [6:0]            csr_wdata,
   input  gdda_pkg::cmd_type     cmd,
   output gdda_pkg::status_type  status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gdda_pkg::rsp_type     rsp_data
);

   logic [6:0]        map_cols_ff, map_rows_ff;
   gdda_pkg::req_type item_ff;
   logic              mem [4096];
   logic              mem_q_ff;
   logic [11:0]       rd_addr;

   logic [1:0]  quad_ff;
   logic [14:0] t_ff, t2_ff, inner_ff;
   logic [15:0] mx_ff, my_ff;
   logic        negx_ff, negy_ff;

   logic signed [7:0] cx_ff, cy_ff, cx_in, cy_in;
   logic [21:0] nx_ff, ny_ff;
   logic [37:0] a_ff, b_ff;
   logic        side_ff, left_ff;

   logic [38:0] rem_ff;
   logic [23:0] low_ff, quo_ff;
   logic [37:0] div_ff;
   logic [23:0] d_ff;
   logic [37:0] den_ff;
   logic        clamp_ff;

   logic              rsp_valid_ff;
   gdda_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [15:0] phase;
   logic [14:0] t0, t_new;
   logic [23:0] mul_a;
   logic [15:0] mul_b;
   logic [39:0] prod;
   logic [15:0] y_mag;
   logic        xstep;
   logic [6:0]  cols, rows;
   logic [21:0] num;
   logic [15:0] m_sel;
   logic [38:0] r2;
   logic        ge;
   logic [46:0] den_scaled;
   logic        span_clamp;
   logic [9:0]  k_rows, k_adj;
   logic [7:0]  out_start;
   logic [8:0]  out_end;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         map_cols_ff <= gdda_pkg::MAP_DIM;
         map_rows_ff <= gdda_pkg::MAP_DIM;
      end else if (csr_valid) begin
         if (csr_index == gdda_pkg::CSR_MAP_COLS) map_cols_ff <= csr_wdata;
         else map_rows_ff <= csr_wdata;
      end
   end

   assign cols = (map_cols_ff > gdda_pkg::MAP_DIM) ? gdda_pkg::MAP_DIM : map_cols_ff;
   assign rows = (map_rows_ff > gdda_pkg::MAP_DIM) ? gdda_pkg::MAP_DIM : map_rows_ff;

   // input beat capture
   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= req_data;
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         gdda_pkg::DP_SIN_M1: begin mul_a = 24'(t_ff);     mul_b = 16'(t_ff);     end
         gdda_pkg::DP_SIN_M2: begin mul_a = gdda_pkg::SIN_C; mul_b = 16'(t2_ff);  end
         gdda_pkg::DP_SIN_M3: begin mul_a = 24'(t2_ff);    mul_b = 16'(inner_ff); end
         gdda_pkg::DP_SIN_M4: begin mul_a = 24'(t_ff);     mul_b = 16'(inner_ff); end
         gdda_pkg::DP_PROD_A: begin mul_a = 24'(nx_ff);    mul_b = my_ff;         end
         gdda_pkg::DP_PROD_B: begin mul_a = 24'(ny_ff);    mul_b = mx_ff;         end
         gdda_pkg::DP_DEN:    begin mul_a = d_ff;          mul_b = gdda_pkg::DEN_K; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod  = 40'(mul_a) * 40'(mul_b);
   assign y_mag = {1'b0, prod[28:14]};

   // quarter-wave reduction of the phase
   assign phase = {item_ff.ray_angle, 4'b0000} + (cmd.axis_y ? 16'd0 : gdda_pkg::QUARTER);
   assign t0    = {1'b0, phase[13:0]};
   assign t_new = phase[14] ? (gdda_pkg::SIN_ONE - t0) : t0;

   // dda step decision and next cell
   always_comb begin
      if (mx_ff == 16'd0)      xstep = 1'b0;
      else if (my_ff == 16'd0) xstep = 1'b1;
      else                     xstep = a_ff < b_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      if (xstep) cx_in = negx_ff ? (cx_ff - 8'sd1) : (cx_ff + 8'sd1);
      else       cy_in = negy_ff ? (cy_ff - 8'sd1) : (cy_ff + 8'sd1);
   end

   assign rd_addr = {cy_in[5:0], cx_in[5:0]};

   // distance numerator and divisor select, used by the saturation test
   assign num   = side_ff ? (ny_ff - gdda_pkg::CELL_Q6) : (nx_ff - gdda_pkg::CELL_Q6);
   assign m_sel = side_ff ? my_ff : mx_ff;

   // one restoring divide step
   assign r2 = {rem_ff[37:0], low_ff[23]};
   assign ge = r2 >= {1'b0, div_ff};

   // span clamp when the wall is at least as tall as the screen
   assign den_scaled = {den_ff, 9'b0} - {4'b0, den_ff, 5'b0};
   assign span_clamp = {10'b0, gdda_pkg::HN} >= den_scaled;

   // wall map store
   always_ff @(posedge clock) begin
      if (cmd.op == gdda_pkg::DP_CLEAR) mem[cmd.clr_addr] <= 1'b0;
      else if (cmd.cell_write) mem[{req_data.cell_row, req_data.cell_col}] <= req_data.cell_is_wall;
      mem_q_ff <= mem[rd_addr];
   end

   // sine, stepper and divider registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         gdda_pkg::DP_SIN_LOAD: begin
            quad_ff <= phase[15:14];
            t_ff    <= t_new;
         end
         gdda_pkg::DP_SIN_M1: t2_ff    <= prod[28:14];
         gdda_pkg::DP_SIN_M2: inner_ff <= gdda_pkg::SIN_B - prod[28:14];
         gdda_pkg::DP_SIN_M3: inner_ff <= gdda_pkg::SIN_A - prod[28:14];
         gdda_pkg::DP_SIN_M4: begin
            if (cmd.axis_y) begin
               my_ff   <= y_mag;
               negy_ff <= quad_ff[1] && (y_mag != 16'd0);
            end else begin
               mx_ff   <= y_mag;
               negx_ff <= quad_ff[1] && (y_mag != 16'd0);
            end
         end
         gdda_pkg::DP_INIT: begin
            cx_ff <= {2'b00, item_ff.pos_x[17:12]};
            cy_ff <= {2'b00, item_ff.pos_y[17:12]};
            nx_ff <= negx_ff ? 22'(item_ff.pos_x[11:0])
                             : gdda_pkg::CELL_Q6 - 22'(item_ff.pos_x[11:0]);
            ny_ff <= negy_ff ? 22'(item_ff.pos_y[11:0])
                             : gdda_pkg::CELL_Q6 - 22'(item_ff.pos_y[11:0]);
            side_ff <= 1'b0;
         end
         gdda_pkg::DP_PROD_A: a_ff <= prod[37:0];
         gdda_pkg::DP_PROD_B: b_ff <= prod[37:0];
         gdda_pkg::DP_STEP: begin
            cx_ff <= cx_in;
            cy_ff <= cy_in;
            if (xstep) begin
               nx_ff   <= nx_ff + gdda_pkg::CELL_Q6;
               a_ff    <= a_ff + {10'b0, my_ff, 12'b0};
               side_ff <= 1'b0;
            end else begin
               ny_ff   <= ny_ff + gdda_pkg::CELL_Q6;
               b_ff    <= b_ff + {10'b0, mx_ff, 12'b0};
               side_ff <= 1'b1;
            end
         end
         gdda_pkg::DP_TEST: left_ff <= status.out_of_map || cmd.force_left;
         gdda_pkg::DP_DIST: begin
            d_ff   <= gdda_pkg::DIST_MAX;
            rem_ff <= 39'(num[21:8]);
            low_ff <= {num[7:0], 16'b0};
            div_ff <= 38'(m_sel);
            quo_ff <= '0;
         end
         gdda_pkg::DP_DIV: begin
            rem_ff <= ge ? (r2 - {1'b0, div_ff}) : r2;
            low_ff <= {low_ff[22:0], 1'b0};
            quo_ff <= {quo_ff[22:0], ge};
         end
         gdda_pkg::DP_DLOAD: d_ff <= quo_ff;
         gdda_pkg::DP_DEN:   den_ff <= prod[37:0] + gdda_pkg::DEN_BIAS;
         gdda_pkg::DP_SPAN: begin
            clamp_ff <= span_clamp;
            rem_ff   <= 39'(gdda_pkg::HN[36:9]);
            low_ff   <= {gdda_pkg::HN[8:0], 15'b0};
            div_ff   <= den_ff;
            quo_ff   <= '0;
         end
         default: ;
      endcase
   end

   // span rows from quotient and remainder
   assign k_rows    = {1'b0, gdda_pkg::SCREEN_ROWS} - {1'b0, quo_ff[8:0]};
   assign k_adj     = k_rows - ((rem_ff != '0) ? 10'd1 : 10'd0);
   assign out_start = clamp_ff ? 8'd0 : k_adj[8:1];
   assign out_end   = clamp_ff ? gdda_pkg::SCREEN_ROWS : ({1'b0, out_start} + quo_ff[8:0]);

   always_comb begin
      rsp_data_in.out_column    = item_ff.column;
      rsp_data_in.hit_side      = side_ff;
      rsp_data_in.left_map      = left_ff;
      rsp_data_in.wall_distance = d_ff;
      rsp_data_in.span_start    = out_start;
      rsp_data_in.span_end      = out_end;
      rsp_data_in.wall_shade    = side_ff ? gdda_pkg::SHADE_H : gdda_pkg::SHADE_V;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // status to the sequencer
   always_comb begin
      status.out_of_map = cx_ff[7] || cy_ff[7] || (cx_ff[6:0] >= cols) || (cy_ff[6:0] >= rows);
      status.wall       = mem_q_ff;
      status.dist_sat   = (m_sel == 16'd0) || ({2'b00, num} >= {m_sel, 8'b0});
      status.span_clamp = span_clamp;
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // checks
   `GDDA_ASSERT(a_rem_below, clock, reset, (cmd.op == gdda_pkg::DP_DIV) |-> (rem_ff < {1'b0, div_ff}), "divider remainder not below divisor")
   `GDDA_ASSERT(a_span_max, clock, reset, cmd.out_load |-> (out_end <= gdda_pkg::SCREEN_ROWS), "span end beyond screen")

endmodule

@@ rtl/grid_dda_ray_caster_top.sv @@
// top level of the grid dda ray caster
//
//   channel  direction  handshake           beat
//   req_     in         req_valid/req_stall  cell write or ray cast item
//   rsp_     out        rsp_valid/rsp_stall  one result per ray cast
//   csr_     in         csr_valid/csr_ready  map_cols (index 0), map_rows (index 1)
//
// a cell write is done as it is taken and the sequencer stays idle; a ray cast steps the grid until it stops
// each grid step runs the step decision state, which also reads the wall map, then the cell test state
// after reset a clearing pass over all 4096 cells empties the wall map; req_stall is high meanwhile
// a finished result sits in the output register; the next beat is taken while it waits
// the configuration port is always ready

module grid_dda_ray_caster_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  gdda_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output gdda_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [6:0]         csr_wdata
);

   gdda_pkg::cmd_type    cmd;
   gdda_pkg::status_type status;

   assign csr_ready = 1'b1;

   // sequencer
   gdda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   gdda_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench of the grid dda ray caster
`timescale 1ns / 1ps

module tb_top;
   import gdda_pkg::*;

   localparam int CLK_PERIOD = 12;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 100;

   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_index;
   logic [6:0] csr_wdata;

   // mirror of the block state
   bit         wall_bits [0:4095];
   logic [6:0] cols_reg;
   logic [6:0] rows_reg;

   rsp_type     pending_hits[$];
   dir_row_type dir_rows[$];
   int          error_count;
   int          send_idle_pct;
   int          stall_pct;
   int          quiet_cycles;

   grid_dda_ray_caster_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
   endtask

   // q14 quarter-wave sine polynomial
   function automatic int sine_q14(logic [15:0] phase);
      longint t, t2, inner, y;
      t = phase[13:0];
      if (phase[14]) t = SIN_ONE - t;
      t2 = (t * t) >> 14;
      inner = SIN_B - ((SIN_C * t2) >> 14);
      inner = SIN_A - ((t2 * inner) >> 14);
      y = (t * inner) >> 14;
      return phase[15] ? -int'(y) : int'(y);
   endfunction

   // walk the grid from the player cell and build the wall span
   function automatic rsp_type cast_ray(req_type r);
      rsp_type    res;
      logic [15:0] phase;
      int         dx, dy, cx, cy, cols, rows;
      bit         negx, negy, xstep, side, left;
      longint     mx, my, fx, fy, nx, ny, num, m, d, den, start, span_end;
      phase = 16'(r.ray_angle * 16);
      dx = sine_q14(phase + QUARTER);
      dy = sine_q14(phase);
      negx = dx < 0;
      negy = dy < 0;
      mx = negx ? -dx : dx;
      my = negy ? -dy : dy;
      cols = (cols_reg > MAP_DIM) ? MAP_DIM : cols_reg;
      rows = (rows_reg > MAP_DIM) ? MAP_DIM : rows_reg;
      cx = r.pos_x / CELL_Q6;
      cy = r.pos_y / CELL_Q6;
      fx = r.pos_x % CELL_Q6;
      fy = r.pos_y % CELL_Q6;
      nx = negx ? fx : CELL_Q6 - fx;
      ny = negy ? fy : CELL_Q6 - fy;
      side = 1'b0;
      left = 1'b0;
      for (int guard = 0; ; guard++) begin
         if (mx == 0) xstep = 1'b0;
         else if (my == 0) xstep = 1'b1;
         else xstep = nx * my < ny * mx;
         if (xstep) begin
            nx += CELL_Q6;
            cx += negx ? -1 : 1;
            side = 1'b0;
         end else begin
            ny += CELL_Q6;
            cy += negy ? -1 : 1;
            side = 1'b1;
         end
         if (cx < 0 || cy < 0 || cx >= cols || cy >= rows) begin
            left = 1'b1;
            break;
         end
         if (wall_bits[cy * 64 + cx]) break;
         if (guard >= STEP_GUARD) begin
            left = 1'b1;
            break;
         end
      end
      num = (side ? ny : nx) - CELL_Q6;
      m = side ? my : mx;
      d = (m == 0) ? DIST_MAX : (num * 65536) / m;
      if (d > DIST_MAX) d = DIST_MAX;
      // span height as an exact fraction
      den = d * DEN_K + DEN_BIAS;
      if (HN >= SCREEN_ROWS * den) begin
         start = 0;
         span_end = SCREEN_ROWS;
      end else begin
         start = (SCREEN_ROWS * den - HN) / (2 * den);
         span_end = start + HN / den;
      end
      res.out_column    = r.column;
      res.hit_side      = side;
      res.left_map      = left;
      res.wall_distance = 24'(d);
      res.span_start    = 8'(start);
      res.span_end      = 9'(span_end);
      res.wall_shade    = side ? SHADE_H : SHADE_V;
      return res;
   endfunction

   // drive one request beat, update the mirror when it is taken
   task automatic send_beat(req_type beat, bit typed, rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      if (beat.op == OP_CAST) pending_hits.push_back(typed ? want : cast_ray(beat));
      else wall_bits[beat.cell_row * 64 + beat.cell_col] = beat.cell_is_wall;
   endtask

   task automatic write_reg(logic idx, logic [6:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_MAP_COLS) cols_reg = value;
      else rows_reg = value;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic req_type random_beat(int p_cast);
      req_type b;
      int      span_x, span_y;
      b = req_type'({$urandom, $urandom, $urandom});
      b.op = ($urandom_range(99) < p_cast) ? OP_CAST : OP_WRITE;
      b.column = $urandom_range(639);
      b.cell_is_wall = $urandom_range(99) < 30;
      span_x = ((cols_reg > MAP_DIM) ? MAP_DIM : cols_reg) * CELL_Q6;
      span_y = ((rows_reg > MAP_DIM) ? MAP_DIM : rows_reg) * CELL_Q6;
      // mostly start inside the map in use
      if ($urandom_range(99) < 85 && span_x > 0 && span_y > 0) begin
         b.pos_x = $urandom_range(span_x - 1);
         b.pos_y = $urandom_range(span_y - 1);
      end
      return b;
   endfunction

   // result checker and receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_hits.size() == 0) begin
            report_mismatch("unexpected result beat", 1, 0);
         end else begin
            rsp_type w;
            w = pending_hits.pop_front();
            if (rsp_data.out_column != w.out_column)
               report_mismatch("out_column", rsp_data.out_column, w.out_column);
            if (rsp_data.hit_side != w.hit_side)
               report_mismatch("hit_side", rsp_data.hit_side, w.hit_side);
            if (rsp_data.left_map != w.left_map)
               report_mismatch("left_map", rsp_data.left_map, w.left_map);
            if (rsp_data.wall_distance != w.wall_distance)
               report_mismatch("wall_distance", rsp_data.wall_distance, w.wall_distance);
            if (rsp_data.span_start != w.span_start)
               report_mismatch("span_start", rsp_data.span_start, w.span_start);
            if (rsp_data.span_end != w.span_end)
               report_mismatch("span_end", rsp_data.span_end, w.span_end);
            if (rsp_data.wall_shade != w.wall_shade)
               report_mismatch("wall_shade", rsp_data.wall_shade, w.wall_shade);
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // directed rows, then random phases
   initial begin
      rsp_type none;
      req_type b;
      int      phase_cfg [8][4] = '{
         '{64, 64, 0, 0}, '{1, 1, 73, 0}, '{127, 127, 0, 73}, '{0, 64, 26, 26},
         '{64, 0, 0, 0}, '{20, 45, 73, 0}, '{64, 64, 0, 73}, '{33, 64, 26, 26}};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_MAP_COLS;
      csr_wdata = '0;
      error_count = 0;
      quiet_cycles = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      cols_reg = 7'd64;
      rows_reg = 7'd64;
      none = '0;
      foreach (wall_bits[i]) wall_bits[i] = 1'b0;

      // empty map: ray runs straight out of the east edge
      b = '0; b.op = OP_CAST;
      dir_rows.push_back('{b, 1'b1, '{10'd0, 1'b0, 1'b1, 24'd1048576, 8'd236, 9'd243, SHADE_V}});
      b = '0; b.op = OP_WRITE; b.cell_col = 6'd1; b.cell_is_wall = 1'b1;
      dir_rows.push_back('{b, 1'b0, none});
      // wall right next to the player: span clamps to the full screen
      b = '0; b.op = OP_CAST; b.pos_x = 18'd2048; b.pos_y = 18'd2048; b.column = 10'd639;
      dir_rows.push_back('{b, 1'b1, '{10'd639, 1'b0, 1'b0, 24'd8192, 8'd0, 9'd480, SHADE_V}});
      foreach (phase_cfg[k]) begin
         b.ray_angle = 12'(k * 512 + (k == 7 ? 511 : 0));
         b.column = 10'(k * 80);
         dir_rows.push_back('{b, 1'b0, none});
      end
      b = '0; b.op = OP_WRITE; b.cell_col = 6'd63; b.cell_row = 6'd63; b.cell_is_wall = 1'b1;
      dir_rows.push_back('{b, 1'b0, none});
      b = '0; b.op = OP_CAST; b.pos_x = 18'h3FFFF; b.pos_y = 18'h3FFFF; b.ray_angle = 12'hFFF;
      dir_rows.push_back('{b, 1'b0, none});
      b.ray_angle = 12'd2048;
      dir_rows.push_back('{b, 1'b0, none});
      b = '0; b.op = OP_WRITE; b.cell_col = 6'd63; b.cell_row = 6'd63;
      dir_rows.push_back('{b, 1'b0, none});
      b = '0; b.op = OP_CAST; b.pos_x = 18'h3FFFF; b.pos_y = 18'd100; b.ray_angle = 12'd3072;
      dir_rows.push_back('{b, 1'b0, none});
      b = '0; b.op = OP_WRITE; b.cell_row = 6'd1; b.cell_is_wall = 1'b1;
      dir_rows.push_back('{b, 1'b0, none});
      // diagonal from a cell corner starts on a tie between the x and y steps
      b = '0; b.op = OP_CAST; b.ray_angle = 12'd512;
      dir_rows.push_back('{b, 1'b0, none});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
      drain();

      foreach (phase_cfg[k]) begin
         write_reg(CSR_MAP_COLS, 7'(phase_cfg[k][0]));
         write_reg(CSR_MAP_ROWS, 7'(phase_cfg[k][1]));
         send_idle_pct = phase_cfg[k][2];
         stall_pct = phase_cfg[k][3];
         for (int n = 0; n < 240; n++) send_beat(random_beat(45), 1'b0, none);
         drain();
      end

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/gdda_pkg.sv
rtl/gdda_ctrl.sv
rtl/gdda_dp.sv
rtl/grid_dda_ray_caster_top.sv
tb/tb_top.sv
